### rtl/plob_pkg.sv
package plob_pkg;

	localparam int DEF_PRICE_LEVELS = 1024;
	localparam int DEF_POOL_SLOTS   = 16;

	// widths that cover the whole parameter range
	localparam int LVL_W  = 16;
	localparam int SLOT_W = 5;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;

	localparam logic [1:0] RPT_ACCEPTED  = 2'd0;
	localparam logic [1:0] RPT_REJECTED  = 2'd1;
	localparam logic [1:0] RPT_CANCELLED = 2'd2;
	localparam logic [1:0] RPT_FILLED    = 2'd3;

	localparam logic CFG_BASE_PRICE = 1'b0;
	localparam logic CFG_HIGHEST_ID = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] req_id;
		logic        is_sell;
		logic [31:0] limit_price;
		logic [31:0] order_qty;
		logic [63:0] submit_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  report_type;
		logic [31:0] report_order_id;
		logic [31:0] contra_order_id;
		logic [31:0] report_price;
		logic [31:0] report_qty;
		logic [63:0] report_time;
		logic        last;
	} rep_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_ADD,
		CMD_DEL,
		CMD_SETQ
	} cmd_op_t;

	// broadcast to every cell
	typedef struct packed {
		cmd_op_t            op;
		logic [SLOT_W-1:0]  idx;
		logic [31:0]        id;
		logic [31:0]        qty;
		logic [LVL_W-1:0]   lvl;
		logic               sell;
		logic [SLOT_W-1:0]  age;
	} cmd_t;

	// best-order candidate traveling down the chain
	typedef struct packed {
		logic               v;
		logic [LVL_W-1:0]   lvl;
		logic [SLOT_W-1:0]  age;
		logic [SLOT_W-1:0]  idx;
	} cand_t;

	// contents of one cell as seen by the controller
	typedef struct packed {
		logic               live;
		logic               sell;
		logic [31:0]        id;
		logic [31:0]        qty;
		logic [LVL_W-1:0]   lvl;
		logic [SLOT_W-1:0]  age;
	} slot_t;

endpackage

### rtl/plob_cell.sv
module plob_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  plob_pkg::cmd_t  cmd,
	input  logic           tok_in,
	input  plob_pkg::cand_t bid_in,
	input  plob_pkg::cand_t ask_in,
	output logic           tok_out,
	output plob_pkg::cand_t bid_out,
	output plob_pkg::cand_t ask_out,
	output plob_pkg::slot_t view
);
	import plob_pkg::*;

	logic              live_q;
	logic              sell_q;
	logic [31:0]       id_q;
	logic [31:0]       qty_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [SLOT_W-1:0] age_q;
	logic              tok_q;
	cand_t             bid_q, ask_q;
	cand_t             my_bid, my_ask;
	logic              sel;

	// higher level wins for bids, lower for asks; older (smaller age) breaks ties
	function automatic cand_t pick_bid(cand_t a, cand_t b);
		cand_t r;
		r = a;
		if (!a.v)
			r = b;
		else if (b.v && (b.lvl > a.lvl || (b.lvl == a.lvl && b.age < a.age)))
			r = b;
		return r;
	endfunction

	function automatic cand_t pick_ask(cand_t a, cand_t b);
		cand_t r;
		r = a;
		if (!a.v)
			r = b;
		else if (b.v && (b.lvl < a.lvl || (b.lvl == a.lvl && b.age < a.age)))
			r = b;
		return r;
	endfunction

	assign sel = (cmd.idx == SLOT_W'(IDX));

	always_comb begin
		my_bid.v   = live_q && !sell_q;
		my_bid.lvl = lvl_q;
		my_bid.age = age_q;
		my_bid.idx = SLOT_W'(IDX);
		my_ask     = my_bid;
		my_ask.v   = live_q && sell_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			case (cmd.op)
				CMD_ADD: if (sel) live_q <= 1'b1;
				CMD_DEL: if (sel) live_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_ADD: begin
				if (sel) begin
					id_q   <= cmd.id;
					qty_q  <= cmd.qty;
					lvl_q  <= cmd.lvl;
					sell_q <= cmd.sell;
					age_q  <= cmd.age;
				end
			end
			CMD_DEL: begin
				// keep ages dense: newer-than-removed orders (larger age) shift down
				if (!sel && live_q && age_q > cmd.age)
					age_q <= age_q - SLOT_W'(1);
			end
			CMD_SETQ: if (sel) qty_q <= cmd.qty;
			default: ;
		endcase
		if (tok_in) begin
			bid_q <= pick_bid(bid_in, my_bid);
			ask_q <= pick_ask(ask_in, my_ask);
		end
	end

	assign tok_out = tok_q;
	assign bid_out = bid_q;
	assign ask_out = ask_q;

	always_comb begin
		view.live = live_q;
		view.sell = sell_q;
		view.id   = id_q;
		view.qty  = qty_q;
		view.lvl  = lvl_q;
		view.age  = age_q;
	end

endmodule

### rtl/price_ladder_order_book.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_t
// rep       out        rep_valid / rep_stall  rep_t
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// Cancel, rejected cancel or undefined request: ST_CANCEL, then ST_FLUSH. Add:
// ST_ADD, a best-order search if accepted, then ST_FLUSH; a modify runs its
// cancel first. A search walks the cell row; each trade adds the report states
// ST_FILL_B and ST_FILL_A and another search. Reports leave through a one-deep
// holding register and an output register; rep_stall only holds the report
// sequencer. Reset clears the live bits at once; no clearing pass.
module price_ladder_order_book #(
	parameter int PRICE_LEVELS = plob_pkg::DEF_PRICE_LEVELS,
	parameter int POOL_SLOTS   = plob_pkg::DEF_POOL_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  plob_pkg::req_t req,
	output logic           rep_valid,
	input  logic           rep_stall,
	output plob_pkg::rep_t rep,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data
);
	import plob_pkg::*;

	localparam int IW    = $clog2(POOL_SLOTS);
	localparam int CNT_W = SLOT_W + 1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CANCEL = 7'b0000010,
		ST_ADD    = 7'b0000100,
		ST_SEARCH = 7'b0001000,
		ST_FILL_B = 7'b0010000,
		ST_FILL_A = 7'b0100000,
		ST_FLUSH  = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [31:0]       base_q, hid_q;
	req_t              req_q;
	rep_t              pend_q, out_q, em_rep, flush_rep;
	logic              pend_v_q, out_v_q, em;
	logic              start_q, start_d;
	logic [IW-1:0]     b_q, a_q;
	logic [31:0]       traded_q, price_q;
	cmd_t              cmd;

	cand_t             bid_c [POOL_SLOTS+1];
	cand_t             ask_c [POOL_SLOTS+1];
	logic              tok_c [POOL_SLOTS+1];
	slot_t             view  [POOL_SLOTS];

	logic              hit, all_live;
	logic [IW-1:0]     hit_idx, free_idx;
	logic [CNT_W-1:0]  live_cnt;
	logic [32:0]       diff;
	logic              bad_add, bad_cancel;
	logic              out_free, emit_ok, do_trade;
	logic [31:0]       qb, qa;
	logic [IW-1:0]     cb, ca;

	assign bid_c[0] = '0;
	assign ask_c[0] = '0;
	assign tok_c[0] = start_q;

	for (genvar g = 0; g < POOL_SLOTS; g++) begin : g_cell
		plob_cell #(.IDX(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok_c[g]),
			.bid_in  (bid_c[g]),
			.ask_in  (ask_c[g]),
			.tok_out (tok_c[g+1]),
			.bid_out (bid_c[g+1]),
			.ask_out (ask_c[g+1]),
			.view    (view[g])
		);
	end

	// id lookup, lowest free slot, live count
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		all_live = 1'b1;
		free_idx = '0;
		live_cnt = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (view[i].live && view[i].id == req_q.req_id) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
			if (!view[i].live) begin
				all_live = 1'b0;
				free_idx = IW'(i);
			end
			live_cnt = live_cnt + CNT_W'(view[i].live);
		end
	end

	assign diff = {1'b0, req_q.limit_price} - {1'b0, base_q};
	assign bad_add = diff[32] || (diff >= 33'(PRICE_LEVELS)) || req_q.order_qty == '0 ||
		req_q.req_id > hid_q || hit || all_live;
	assign bad_cancel = (req_q.req_type != REQ_CANCEL && req_q.req_type != REQ_MODIFY) ||
		req_q.req_id > hid_q || !hit;

	assign out_free = !out_v_q || !rep_stall;
	assign emit_ok  = !pend_v_q || out_free;

	assign cb = bid_c[POOL_SLOTS].idx[IW-1:0];
	assign ca = ask_c[POOL_SLOTS].idx[IW-1:0];
	assign qb = view[cb].qty;
	assign qa = view[ca].qty;
	assign do_trade = bid_c[POOL_SLOTS].v && ask_c[POOL_SLOTS].v &&
		bid_c[POOL_SLOTS].lvl >= ask_c[POOL_SLOTS].lvl;

	always_comb begin
		state_d = state_q;
		em      = 1'b0;
		em_rep  = '0;
		start_d = 1'b0;
		cmd     = '0;
		cmd.op  = CMD_NOP;
		em_rep.report_order_id = req_q.req_id;
		em_rep.report_time     = req_q.submit_time;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid)
					state_d = (req.req_type == REQ_ADD) ? ST_ADD : ST_CANCEL;
			end
			ST_CANCEL: begin
				if (emit_ok) begin
					em = 1'b1;
					if (bad_cancel) begin
						em_rep.report_type = RPT_REJECTED;
						state_d = ST_FLUSH;
					end else begin
						cmd.op  = CMD_DEL;
						cmd.idx = SLOT_W'(hit_idx);
						cmd.age = view[hit_idx].age;
						em_rep.report_type  = RPT_CANCELLED;
						em_rep.report_price = base_q + 32'(view[hit_idx].lvl);
						state_d = (req_q.req_type == REQ_MODIFY) ? ST_ADD : ST_FLUSH;
					end
				end
			end
			ST_ADD: begin
				if (emit_ok) begin
					em = 1'b1;
					em_rep.report_price = req_q.limit_price;
					em_rep.report_qty   = req_q.order_qty;
					if (bad_add) begin
						em_rep.report_type = RPT_REJECTED;
						state_d = ST_FLUSH;
					end else begin
						cmd.op   = CMD_ADD;
						cmd.idx  = SLOT_W'(free_idx);
						cmd.id   = req_q.req_id;
						cmd.qty  = req_q.order_qty;
						cmd.lvl  = diff[LVL_W-1:0];
						cmd.sell = req_q.is_sell;
						cmd.age  = live_cnt[SLOT_W-1:0];
						em_rep.report_type = RPT_ACCEPTED;
						start_d = 1'b1;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (tok_c[POOL_SLOTS])
					state_d = do_trade ? ST_FILL_B : ST_FLUSH;
			end
			ST_FILL_B: begin
				if (emit_ok) begin
					em = 1'b1;
					em_rep.report_type     = RPT_FILLED;
					em_rep.report_order_id = view[b_q].id;
					em_rep.contra_order_id = view[a_q].id;
					em_rep.report_price    = price_q;
					em_rep.report_qty      = traded_q;
					em_rep.report_time     = '0;
					cmd.idx = SLOT_W'(b_q);
					cmd.age = view[b_q].age;
					cmd.qty = view[b_q].qty - traded_q;
					cmd.op  = (view[b_q].qty == traded_q) ? CMD_DEL : CMD_SETQ;
					state_d = ST_FILL_A;
				end
			end
			ST_FILL_A: begin
				if (emit_ok) begin
					em = 1'b1;
					em_rep.report_type     = RPT_FILLED;
					em_rep.report_order_id = view[a_q].id;
					em_rep.contra_order_id = view[b_q].id;
					em_rep.report_price    = price_q;
					em_rep.report_qty      = traded_q;
					em_rep.report_time     = '0;
					cmd.idx = SLOT_W'(a_q);
					cmd.age = view[a_q].age;
					cmd.qty = view[a_q].qty - traded_q;
					cmd.op  = (view[a_q].qty == traded_q) ? CMD_DEL : CMD_SETQ;
					start_d = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_FLUSH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		flush_rep      = pend_q;
		flush_rep.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			base_q   <= '0;
			hid_q    <= 32'd65535;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			start_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
			if (cfg_we) begin
				if (cfg_index == CFG_BASE_PRICE)
					base_q <= cfg_data;
				else
					hid_q <= cfg_data;
			end
			if ((em && pend_v_q) || (state_q == ST_FLUSH && out_free))
				out_v_q <= 1'b1;
			else if (!rep_stall)
				out_v_q <= 1'b0;
			if (em)
				pend_v_q <= 1'b1;
			else if (state_q == ST_FLUSH && out_free)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid)
			req_q <= req;
		if (em) begin
			pend_q <= em_rep;
			if (pend_v_q)
				out_q <= pend_q;
		end else if (state_q == ST_FLUSH && out_free) begin
			out_q <= flush_rep;
		end
		if (state_q == ST_SEARCH && tok_c[POOL_SLOTS]) begin
			b_q      <= cb;
			a_q      <= ca;
			traded_q <= (qb < qa) ? qb : qa;
			price_q  <= base_q + 32'(ask_c[POOL_SLOTS].lvl);
		end
	end

	assign rep_valid = out_v_q;
	assign rep       = out_q;

endmodule

### verif/tb_price_ladder_order_book.sv
module tb_price_ladder_order_book;
	timeunit 1ns;
	timeprecision 1ps;

	import plob_pkg::*;

	localparam int LEVELS = DEF_PRICE_LEVELS;
	localparam int POOL = DEF_POOL_SLOTS;
	localparam logic [4:0] NO_SLOT = 5'h1f;
	localparam logic [1:0] REQ_UNDEF = 2'd3;
	localparam int SETTLE_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rep_valid;
	logic rep_stall;
	rep_t rep;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;

	price_ladder_order_book u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rep_valid(rep_valid), .rep_stall(rep_stall), .rep(rep),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- book model ----------------
	logic [31:0] bk_id[POOL];
	logic [31:0] bk_qty[POOL];
	logic [9:0] bk_lvl[POOL];
	logic bk_sell[POOL];
	logic bk_live[POOL];
	logic [4:0] bk_next[POOL];
	logic [4:0] bk_prev[POOL];
	logic [4:0] bid_hd[LEVELS];
	logic [4:0] bid_tl[LEVELS];
	logic [4:0] ask_hd[LEVELS];
	logic [4:0] ask_tl[LEVELS];
	int top_bid;
	int top_ask;
	logic [31:0] cur_base;
	logic [31:0] cur_max_id;

	rep_t reports_due[$];
	rep_t req_reports[$];

	int errors;
	int n_reqs;
	int n_reports;
	int n_fills;
	int send_idle_pct;
	int stall_pct;

	function automatic void book_reset();
		for (int i = 0; i < POOL; i++) begin
			bk_live[i] = 1'b0;
			bk_next[i] = NO_SLOT;
			bk_prev[i] = NO_SLOT;
		end
		for (int l = 0; l < LEVELS; l++) begin
			bid_hd[l] = NO_SLOT;
			bid_tl[l] = NO_SLOT;
			ask_hd[l] = NO_SLOT;
			ask_tl[l] = NO_SLOT;
		end
		top_bid = -1;
		top_ask = -1;
		cur_base = 32'd0;
		cur_max_id = 32'd65535;
	endfunction

	function automatic void note(logic [1:0] kind, logic [31:0] id, logic [31:0] contra,
			logic [31:0] price, logic [31:0] qty, logic [63:0] stamp);
		rep_t r;
		r.report_type = kind;
		r.report_order_id = id;
		r.contra_order_id = contra;
		r.report_price = price;
		r.report_qty = qty;
		r.report_time = stamp;
		r.last = 1'b0;
		req_reports.push_back(r);
	endfunction

	function automatic int find_order(logic [31:0] id);
		for (int i = 0; i < POOL; i++)
			if (bk_live[i] && bk_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void link_order(logic [4:0] s);
		logic [9:0] l;
		logic [4:0] t;
		l = bk_lvl[s];
		t = bk_sell[s] ? ask_tl[l] : bid_tl[l];
		bk_prev[s] = t;
		bk_next[s] = NO_SLOT;
		if (t == NO_SLOT) begin
			if (bk_sell[s]) ask_hd[l] = s;
			else bid_hd[l] = s;
		end else begin
			bk_next[t] = s;
		end
		if (bk_sell[s]) ask_tl[l] = s;
		else bid_tl[l] = s;
	endfunction

	function automatic void unlink_order(logic [4:0] s);
		logic [9:0] l;
		logic [4:0] p;
		logic [4:0] n;
		l = bk_lvl[s];
		p = bk_prev[s];
		n = bk_next[s];
		if (p != NO_SLOT) bk_next[p] = n;
		else if (bk_sell[s]) ask_hd[l] = n;
		else bid_hd[l] = n;
		if (n != NO_SLOT) bk_prev[n] = p;
		else if (bk_sell[s]) ask_tl[l] = p;
		else bid_tl[l] = p;
		bk_prev[s] = NO_SLOT;
		bk_next[s] = NO_SLOT;
		bk_live[s] = 1'b0;
	endfunction

	function automatic void rescan_bids();
		top_bid = -1;
		for (int l = LEVELS - 1; l >= 0; l--)
			if (bid_hd[l] != NO_SLOT) begin
				top_bid = l;
				break;
			end
	endfunction

	function automatic void rescan_asks();
		top_ask = -1;
		for (int l = 0; l < LEVELS; l++)
			if (ask_hd[l] != NO_SLOT) begin
				top_ask = l;
				break;
			end
	endfunction

	function automatic void cross_book();
		logic [4:0] b;
		logic [4:0] a;
		logic [31:0] traded;
		logic [31:0] price;
		while (top_bid >= 0 && top_ask >= 0 && top_bid >= top_ask) begin
			b = bid_hd[top_bid];
			a = ask_hd[top_ask];
			if (b == NO_SLOT) begin
				rescan_bids();
				continue;
			end
			if (a == NO_SLOT) begin
				rescan_asks();
				continue;
			end
			traded = (bk_qty[b] < bk_qty[a]) ? bk_qty[b] : bk_qty[a];
			price = cur_base + 32'(bk_lvl[a]);
			bk_qty[b] -= traded;
			bk_qty[a] -= traded;
			note(RPT_FILLED, bk_id[b], bk_id[a], price, traded, 64'd0);
			note(RPT_FILLED, bk_id[a], bk_id[b], price, traded, 64'd0);
			if (bk_qty[b] == 0) begin
				unlink_order(b);
				if (bid_hd[top_bid] == NO_SLOT) rescan_bids();
			end
			if (bk_qty[a] == 0) begin
				unlink_order(a);
				if (ask_hd[top_ask] == NO_SLOT) rescan_asks();
			end
		end
	endfunction

	function automatic void book_add(req_t r);
		logic [32:0] diff;
		int s;
		diff = {1'b0, r.limit_price} - {1'b0, cur_base};
		s = -1;
		if (r.limit_price < cur_base || diff >= LEVELS || r.order_qty == 0 ||
				r.req_id > cur_max_id || find_order(r.req_id) >= 0) begin
			note(RPT_REJECTED, r.req_id, 0, r.limit_price, r.order_qty, r.submit_time);
			return;
		end
		for (int i = 0; i < POOL; i++)
			if (!bk_live[i]) begin
				s = i;
				break;
			end
		if (s < 0) begin
			note(RPT_REJECTED, r.req_id, 0, r.limit_price, r.order_qty, r.submit_time);
			return;
		end
		bk_id[s] = r.req_id;
		bk_qty[s] = r.order_qty;
		bk_lvl[s] = diff[9:0];
		bk_sell[s] = r.is_sell;
		bk_live[s] = 1'b1;
		link_order(5'(s));
		if (!r.is_sell) begin
			if (int'(diff[9:0]) > top_bid) top_bid = diff[9:0];
		end else if (top_ask < 0 || int'(diff[9:0]) < top_ask) begin
			top_ask = diff[9:0];
		end
		note(RPT_ACCEPTED, r.req_id, 0, r.limit_price, r.order_qty, r.submit_time);
		cross_book();
	endfunction

	function automatic bit book_cancel(req_t r);
		int s;
		logic [9:0] l;
		logic side;
		s = (r.req_id > cur_max_id) ? -1 : find_order(r.req_id);
		if (s < 0) begin
			note(RPT_REJECTED, r.req_id, 0, 0, 0, r.submit_time);
			return 1'b0;
		end
		l = bk_lvl[s];
		side = bk_sell[s];
		unlink_order(5'(s));
		if (!side && top_bid == int'(l) && bid_hd[l] == NO_SLOT) rescan_bids();
		if (side && top_ask == int'(l) && ask_hd[l] == NO_SLOT) rescan_asks();
		note(RPT_CANCELLED, r.req_id, 0, cur_base + 32'(l), 0, r.submit_time);
		return 1'b1;
	endfunction

	function automatic void predict_request(req_t r);
		req_reports.delete();
		case (r.req_type)
			REQ_ADD: book_add(r);
			REQ_CANCEL: void'(book_cancel(r));
			REQ_MODIFY: if (book_cancel(r)) book_add(r);
			default: note(RPT_REJECTED, r.req_id, 0, 0, 0, r.submit_time);
		endcase
		if (req_reports.size() > 0) req_reports[$].last = 1'b1;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	int quiet_cycles;

	always @(posedge clk) begin
		rep_t w;
		if (arst_n && rep_valid && !rep_stall) begin
			n_reports++;
			if (rep.report_type == RPT_FILLED) n_fills++;
			if (reports_due.size() == 0) begin
				report_mismatch("unexpected report id", rep.report_order_id, 0);
			end else begin
				w = reports_due.pop_front();
				if (rep.report_type != w.report_type)
					report_mismatch("report_type", rep.report_type, w.report_type);
				if (rep.report_order_id != w.report_order_id)
					report_mismatch("report_order_id", rep.report_order_id, w.report_order_id);
				if (rep.contra_order_id != w.contra_order_id)
					report_mismatch("contra_order_id", rep.contra_order_id, w.contra_order_id);
				if (rep.report_price != w.report_price)
					report_mismatch("report_price", rep.report_price, w.report_price);
				if (rep.report_qty != w.report_qty)
					report_mismatch("report_qty", rep.report_qty, w.report_qty);
				if (rep.report_time != w.report_time)
					report_mismatch("report_time", rep.report_time, w.report_time);
				if (rep.last != w.last)
					report_mismatch("last", rep.last, w.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rep_valid && !rep_stall) || (req_valid && !req_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		rep_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
	end

	// ---------------- stimulus ----------------
	typedef struct {
		req_t r;
		bit typed;
		rep_t want;
	} row_t;

	row_t rows[$];

	function automatic req_t mk(logic [1:0] kind, logic [31:0] id, logic side,
			logic [31:0] price, logic [31:0] qty);
		req_t r;
		r.req_type = kind;
		r.req_id = id;
		r.is_sell = side;
		r.limit_price = price;
		r.order_qty = qty;
		r.submit_time = {$urandom, $urandom};
		return r;
	endfunction

	function automatic void add_row(req_t r);
		row_t x;
		x.r = r;
		x.typed = 1'b0;
		x.want = '0;
		rows.push_back(x);
	endfunction

	// single-report rows whose outcome is plain from the request alone
	function automatic void add_typed(req_t r, logic [1:0] kind, logic [31:0] price,
			logic [31:0] qty);
		row_t x;
		x.r = r;
		x.typed = 1'b1;
		x.want.report_type = kind;
		x.want.report_order_id = r.req_id;
		x.want.contra_order_id = 32'd0;
		x.want.report_price = price;
		x.want.report_qty = qty;
		x.want.report_time = r.submit_time;
		x.want.last = 1'b1;
		rows.push_back(x);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int k;
		int p;
		int q;
		k = $urandom_range(0, 99);
		r.req_type = (k < 50) ? REQ_ADD : (k < 68) ? REQ_CANCEL :
			(k < 90) ? REQ_MODIFY : (k < 93) ? REQ_UNDEF : REQ_ADD;
		r.is_sell = $urandom_range(0, 1);
		r.submit_time = {$urandom, $urandom};
		if (k >= 93) begin
			r.req_id = $urandom;
			r.limit_price = $urandom;
			r.order_qty = $urandom;
			return r;
		end
		r.req_id = $urandom_range(0, 47);
		p = $urandom_range(0, 99);
		if (p < 88) r.limit_price = cur_base + 32'd480 + $urandom_range(0, 40);
		else if (p < 92) r.limit_price = cur_base;
		else if (p < 96) r.limit_price = cur_base + 32'd1023;
		else if (p < 98) r.limit_price = cur_base - 32'd1;
		else r.limit_price = cur_base + 32'd1024;
		q = $urandom_range(0, 99);
		if (q < 92) r.order_qty = $urandom_range(1, 25);
		else if (q < 96) r.order_qty = 32'd0;
		else r.order_qty = $urandom;
		return r;
	endfunction

	task automatic send(req_t r, bit typed, rep_t want);
		forever begin
			@(negedge clk);
			if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
				req_valid <= 1'b0;
			end else begin
				break;
			end
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		predict_request(r);
		if (typed) reports_due.push_back(want);
		else foreach (req_reports[i]) reports_due.push_back(req_reports[i]);
		n_reqs++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (reports_due.size() > 0) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BASE_PRICE) cur_base = value;
		else cur_max_id = value;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 73; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 73; end
			default: begin send_idle_pct = 28; stall_pct = 28; end
		endcase
	endtask

	logic [31:0] phase_base[6];
	logic [31:0] phase_max_id[6];

	initial begin
		rep_t none;
		none = '0;
		errors = 0;
		n_reqs = 0;
		n_reports = 0;
		n_fills = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rep_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_PRICE;
		cfg_data = 32'd0;
		book_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: rejects, crossing, modify, extremes
		add_typed(mk(REQ_CANCEL, 5, 0, 7, 7), RPT_REJECTED, 0, 0);
		add_typed(mk(REQ_UNDEF, 32'hffffffff, 1, 9, 9), RPT_REJECTED, 0, 0);
		add_typed(mk(REQ_ADD, 1, 0, 100, 10), RPT_ACCEPTED, 100, 10);
		add_typed(mk(REQ_ADD, 1, 1, 200, 3), RPT_REJECTED, 200, 3);
		add_typed(mk(REQ_ADD, 2, 0, 1024, 3), RPT_REJECTED, 1024, 3);
		add_typed(mk(REQ_ADD, 3, 1, 50, 0), RPT_REJECTED, 50, 0);
		add_typed(mk(REQ_ADD, 70000, 0, 50, 4), RPT_REJECTED, 50, 4);
		add_typed(mk(REQ_ADD, 32'hffffffff, 1, 32'hffffffff, 32'hffffffff),
			RPT_REJECTED, 32'hffffffff, 32'hffffffff);
		add_typed(mk(REQ_MODIFY, 9, 0, 10, 10), RPT_REJECTED, 0, 0);
		add_row(mk(REQ_ADD, 4, 1, 100, 4));
		add_row(mk(REQ_ADD, 5, 1, 90, 10));
		add_row(mk(REQ_MODIFY, 1, 0, 1023, 5));
		add_row(mk(REQ_CANCEL, 5, 0, 0, 0));
		add_row(mk(REQ_ADD, 0, 0, 0, 32'hffffffff));
		add_row(mk(REQ_ADD, 65535, 1, 1023, 1));
		for (int i = 20; i < 32; i++) add_row(mk(REQ_ADD, i, 0, 1, 1));
		add_row(mk(REQ_ADD, 0, 1, 0, 32'hffffffff));
		foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].typed ? rows[i].want : none);

		phase_base = '{32'd1000, 32'hfffffc00, 32'd0, 32'h7ffffe00, 32'hffffffff, 32'd0};
		phase_max_id = '{32'd40, 32'hfffffffe, 32'd0, 32'd47, 32'hfffffffe, 32'd65535};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_BASE_PRICE, phase_base[ph]);
			write_reg(CFG_HIGHEST_ID, phase_max_id[ph]);
			set_idling(ph % 4);
			for (int n = 0; n < 80; n++) begin
				if (n == 40) drain();
				send(random_request(), 1'b0, none);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests over six register settings, %0d reports incl. %0d fills",
			n_reqs, n_reports, n_fills);
		$display("idling phases: none, sender gaps, receiver stalls, both");
		if (errors == 0 && reports_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
